@@ hw/rtl/swpm_pkg.sv @@
// shared constants, types and helpers of the sliding window packet meter
package swpm_pkg;

  // per-channel fifo geometry
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned ADDR_W     = IDX_W + 1;
  localparam int unsigned MEM_DEPTH  = 2 ** ADDR_W;

  // field widths
  localparam int unsigned TS_W    = 48;
  localparam int unsigned NB_W    = 16;
  localparam int unsigned WIN_W   = 31;
  localparam int unsigned SPAN_W  = 50;
  localparam int unsigned OSPAN_W = 49;
  localparam int unsigned PKT_W   = 9;
  localparam int unsigned BYTES_W = 24;

  // configuration register indexes
  localparam logic REG_SEND_WINDOW = 1'b0;
  localparam logic REG_RECV_WINDOW = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one stored fifo entry: gap in the upper bits, packet size below
  typedef struct packed {
    logic [TS_W-1:0] gap;
    logic [NB_W-1:0] nbytes;
  } entry_t;

  // access to the entry store
  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    addr_t  addr;
    entry_t wdata;
  } store_req_t;

  // one result item
  typedef struct packed {
    logic               rejected;
    logic [BYTES_W-1:0] bytes;
    logic [PKT_W-1:0]   packets;
    logic [OSPAN_W-1:0] span;
  } result_t;

  // circular index advance
  function automatic idx_t next_idx(idx_t i);
    idx_t r;
    r = (i == IDX_W'(FIFO_DEPTH - 1)) ? '0 : i + idx_t'(1);
    return r;
  endfunction

endpackage

@@ hw/rtl/swpm_store.sv @@
// single-port entry store holding both channel fifos, registered read
module swpm_store (
  input  logic                clk_i,
  input  swpm_pkg::store_req_t req_i,
  output swpm_pkg::entry_t     rdata_o
);
  import swpm_pkg::*;

  entry_t mem_q [MEM_DEPTH];
  entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/swpm_engine.sv @@
// per-channel fifo bookkeeping and the append / evict sequencer
module swpm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_ch_i,
  input  logic [swpm_pkg::TS_W-1:0]   in_ts_i,
  input  logic [swpm_pkg::NB_W-1:0]   in_nb_i,
  input  logic [swpm_pkg::WIN_W-1:0]  send_win_i,
  input  logic [swpm_pkg::WIN_W-1:0]  recv_win_i,
  output swpm_pkg::store_req_t        req_o,
  input  swpm_pkg::entry_t            rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output swpm_pkg::result_t           res_o
);
  import swpm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FRD  = 3'd1;
  localparam logic [2:0] ST_FPOP = 3'd2;
  localparam logic [2:0] ST_APP  = 3'd3;
  localparam logic [2:0] ST_ERD  = 3'd4;
  localparam logic [2:0] ST_ECHK = 3'd5;
  localparam logic [2:0] ST_RES  = 3'd6;

  logic [2:0] st_q, st_d;

  // item being worked on
  logic            ch_q, ch_d;
  logic [TS_W-1:0] ts_q, ts_d;
  logic [NB_W-1:0] nb_q, nb_d;
  logic [TS_W-1:0] gap_q, gap_d;
  logic            rej_q, rej_d;

  // per-channel state
  idx_t               head_q [2];
  idx_t               head_d [2];
  idx_t               tail_q [2];
  idx_t               tail_d [2];
  cnt_t               cnt_q [2];
  cnt_t               cnt_d [2];
  logic [SPAN_W-1:0]  span_q [2];
  logic [SPAN_W-1:0]  span_d [2];
  logic [BYTES_W-1:0] bytes_q [2];
  logic [BYTES_W-1:0] bytes_d [2];
  logic [TS_W-1:0]    last_q [2];
  logic [TS_W-1:0]    last_d [2];

  logic [SPAN_W-1:0] thr;
  logic [WIN_W-1:0]  win;

  assign win = ch_q ? recv_win_i : send_win_i;
  assign thr = SPAN_W'(win) + SPAN_W'(rdata_i.gap);

  assign in_ready_o  = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_RES);

  // result fields of the current channel
  always_comb begin
    res_o.rejected = rej_q;
    res_o.bytes    = bytes_q[ch_q];
    res_o.packets  = PKT_W'(cnt_q[ch_q]);
    res_o.span     = span_q[ch_q][OSPAN_W-1:0];
  end

  // sequencer and next state
  always_comb begin
    st_d    = st_q;
    ch_d    = ch_q;
    ts_d    = ts_q;
    nb_d    = nb_q;
    gap_d   = gap_q;
    rej_d   = rej_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    span_d  = span_q;
    bytes_d = bytes_q;
    last_d  = last_q;
    req_o   = '0;
    req_o.addr = {ch_q, head_q[ch_q]};

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d = in_ch_i;
          ts_d = in_ts_i;
          nb_d = in_nb_i;
          if (last_q[in_ch_i] != '0 && in_ts_i < last_q[in_ch_i]) begin
            rej_d = 1'b1;
            st_d  = ST_RES;
          end else begin
            rej_d = 1'b0;
            gap_d = (last_q[in_ch_i] != '0) ? in_ts_i - last_q[in_ch_i] : '0;
            st_d  = (cnt_q[in_ch_i] == CNT_W'(FIFO_DEPTH)) ? ST_FRD : ST_APP;
          end
        end
      end
      // full fifo: read the oldest entry
      ST_FRD: begin
        req_o.rd_en = 1'b1;
        st_d        = ST_FPOP;
      end
      // full fifo: drop the oldest entry
      ST_FPOP: begin
        span_d[ch_q]  = span_q[ch_q] - SPAN_W'(rdata_i.gap);
        bytes_d[ch_q] = bytes_q[ch_q] - BYTES_W'(rdata_i.nbytes);
        cnt_d[ch_q]   = cnt_q[ch_q] - cnt_t'(1);
        head_d[ch_q]  = next_idx(head_q[ch_q]);
        st_d          = ST_APP;
      end
      // append the new entry and update the sums
      ST_APP: begin
        req_o.wr_en        = 1'b1;
        req_o.addr         = {ch_q, tail_q[ch_q]};
        req_o.wdata.gap    = gap_q;
        req_o.wdata.nbytes = nb_q;
        tail_d[ch_q]  = next_idx(tail_q[ch_q]);
        last_d[ch_q]  = ts_q;
        span_d[ch_q]  = span_q[ch_q] + SPAN_W'(gap_q);
        bytes_d[ch_q] = bytes_q[ch_q] + BYTES_W'(nb_q);
        cnt_d[ch_q]   = cnt_q[ch_q] + cnt_t'(1);
        st_d          = ST_ERD;
      end
      // eviction: read the oldest entry
      ST_ERD: begin
        req_o.rd_en = 1'b1;
        st_d        = ST_ECHK;
      end
      // eviction: drop it while the span still covers the window
      ST_ECHK: begin
        if (span_q[ch_q] < thr) begin
          st_d = ST_RES;
        end else begin
          span_d[ch_q]  = span_q[ch_q] - SPAN_W'(rdata_i.gap);
          bytes_d[ch_q] = bytes_q[ch_q] - BYTES_W'(rdata_i.nbytes);
          cnt_d[ch_q]   = cnt_q[ch_q] - cnt_t'(1);
          head_d[ch_q]  = next_idx(head_q[ch_q]);
          st_d          = (cnt_q[ch_q] == cnt_t'(1)) ? ST_RES : ST_ERD;
        end
      end
      ST_RES: begin
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      rej_q <= 1'b0;
      ch_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        cnt_q[i]   <= '0;
        span_q[i]  <= '0;
        bytes_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else begin
      st_q    <= st_d;
      rej_q   <= rej_d;
      ch_q    <= ch_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      span_q  <= span_d;
      bytes_q <= bytes_d;
      last_q  <= last_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    ts_q  <= ts_d;
    nb_q  <= nb_d;
    gap_q <= gap_d;
  end

endmodule

@@ hw/rtl/sliding_window_packet_meter_core.sv @@
// sequence: a full channel fifo first has its oldest entry read and dropped; the new entry
//   is appended, then the oldest entry is read and checked, again after each eviction that
//   leaves the fifo nonempty; a rejected transfer goes straight to the result; one item at
//   a time, set by the single store port (read, then decide), till the result is registered
// reset: windows go to 1000000 us, all channel sums, counts and stamps clear;
//   the entry store is not cleared, only entries held in a fifo are ever read
module sliding_window_packet_meter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [swpm_pkg::WIN_W-1:0] cfg_data_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // time_stamp[47:0], packet_bytes[63:48]
  input  logic [0:0]                 s_axis_tuser,  // opcode[0]
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [87:0]                m_axis_tdata,  // window_span[48:0], window_packets[57:49],
                                                    // window_bytes[81:58], zero[87:82]
  output logic [0:0]                 m_axis_tuser   // rejected[0]
);
  import swpm_pkg::*;

  logic [WIN_W-1:0] send_win_q, recv_win_q;
  store_req_t       req;
  entry_t           rdata;
  logic             res_valid, res_ready;
  result_t          res;
  logic             m_valid_q, m_valid_d;
  result_t          m_res_q;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_win_q <= WINDOW_RESET;
      recv_win_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEND_WINDOW: send_win_q <= cfg_data_i;
        REG_RECV_WINDOW: recv_win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  swpm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_ch_i     (s_axis_tuser[0]),
    .in_ts_i     (s_axis_tdata[TS_W-1:0]),
    .in_nb_i     (s_axis_tdata[TS_W+NB_W-1:TS_W]),
    .send_win_i  (send_win_q),
    .recv_win_i  (recv_win_q),
    .req_o       (req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  swpm_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_ready) begin
      m_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_res_q.bytes, m_res_q.packets, m_res_q.span};
  assign m_axis_tuser  = m_res_q.rejected;

endmodule

@@ hw/rtl/swpm_checker.sv @@
// port-level checks of the packet meter and their binding
module swpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);
  import swpm_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item in flight: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // an accepted item gives no new result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // packet count stays within the fifo depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[57:49] <= PKT_W'(FIFO_DEPTH))
    else $error("packet count beyond fifo depth");

endmodule

bind sliding_window_packet_meter_core swpm_checker u_checker (.*);

@@ verif/sliding_window_packet_meter_core_tb.sv @@
// self-checking testbench of the two-channel sliding window packet meter
import swpm_pkg::*;

// running copy of both channel windows and the queue of sums still to come
class window_meter_board;
  entry_t              held_q[2][$];
  logic [SPAN_W-1:0]   span_sum[2];
  logic [BYTES_W-1:0]  byte_sum[2];
  logic [TS_W-1:0]     last_ts[2];
  logic [WIN_W-1:0]    window[2];
  result_t             pending_sums[$];
  int                  errors;
  int                  checked;
  int                  rejects;
  int                  evictions;
  int                  full_drops;
  int                  empty_windows;

  function new();
    for (int c = 0; c < 2; c++) begin
      span_sum[c] = '0;
      byte_sum[c] = '0;
      last_ts[c]  = '0;
      window[c]   = WINDOW_RESET;
    end
    errors        = 0;
    checked       = 0;
    rejects       = 0;
    evictions     = 0;
    full_drops    = 0;
    empty_windows = 0;
  endfunction

  function void set_window(logic idx, logic [WIN_W-1:0] value);
    window[idx] = value;
  endfunction

  // take the oldest entry off the channel sums
  function void drop_oldest(int c);
    entry_t e;
    e = held_q[c][0];
    held_q[c].delete(0);
    span_sum[c] = span_sum[c] - SPAN_W'(e.gap);
    byte_sum[c] = byte_sum[c] - BYTES_W'(e.nbytes);
  endfunction

  // update the channel for one accepted packet event and queue its sums
  function void note_packet(logic ch, logic [TS_W-1:0] ts, logic [NB_W-1:0] nb);
    int          c;
    logic [63:0] gap;
    logic [63:0] oldest;
    logic [63:0] span_wide;
    logic [63:0] limit;
    entry_t      e;
    result_t     r;
    c = ch ? 1 : 0;
    r.rejected = 1'b0;
    if (last_ts[c] != '0 && ts < last_ts[c]) begin
      r.rejected = 1'b1;
      rejects++;
    end else begin
      gap = (last_ts[c] != '0) ? {16'd0, ts - last_ts[c]} : 64'd0;
      // full fifo: make room before the append
      if (held_q[c].size() >= FIFO_DEPTH) begin
        drop_oldest(c);
        full_drops++;
      end
      e.gap    = gap[TS_W-1:0];
      e.nbytes = nb;
      held_q[c].insert(held_q[c].size(), e);
      last_ts[c]  = ts;
      span_sum[c] = span_sum[c] + gap[SPAN_W-1:0];
      byte_sum[c] = byte_sum[c] + {8'd0, nb};
      // evict while the span without the oldest gap still covers the window
      while (held_q[c].size() > 0) begin
        oldest    = {16'd0, held_q[c][0].gap};
        span_wide = {14'd0, span_sum[c]};
        limit     = {33'd0, window[c]} + oldest;
        if (span_wide < limit) break;
        drop_oldest(c);
        evictions++;
      end
      if (held_q[c].size() == 0) empty_windows++;
    end
    r.span    = span_sum[c][OSPAN_W-1:0];
    r.packets = PKT_W'(held_q[c].size());
    r.bytes   = byte_sum[c];
    pending_sums.insert(pending_sums.size(), r);
  endfunction

  // compare one result transfer with the oldest expected sums
  function void check_sums(logic [87:0] data, logic user);
    result_t want;
    checked++;
    if (pending_sums.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got span %0d packets %0d bytes %0d",
               $time, data[48:0], data[57:49], data[81:58]);
      return;
    end
    want = pending_sums[0];
    pending_sums.delete(0);
    if (data[48:0] !== want.span) begin
      errors++;
      $display("%0t: window_span expected %0d, got %0d", $time, want.span, data[48:0]);
    end
    if (data[57:49] !== want.packets) begin
      errors++;
      $display("%0t: window_packets expected %0d, got %0d", $time, want.packets,
               data[57:49]);
    end
    if (data[81:58] !== want.bytes) begin
      errors++;
      $display("%0t: window_bytes expected %0d, got %0d", $time, want.bytes, data[81:58]);
    end
    if (data[87:82] !== 6'd0) begin
      errors++;
      $display("%0t: padding bits expected 0, got %0h", $time, data[87:82]);
    end
    if (user !== want.rejected) begin
      errors++;
      $display("%0t: rejected expected %0d, got %0d", $time, want.rejected, user);
    end
  endfunction
endclass

module sliding_window_packet_meter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              HOLD_OFF_CYCLES = 400;
  localparam logic            CH_SEND         = 1'b0;
  localparam logic            CH_RECV         = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_MAX     = '1;
  localparam logic [TS_W-1:0]  STAMP_MAX      = '1;
  localparam logic [NB_W-1:0]  BYTES_MAX      = '1;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = REG_SEND_WINDOW;
  logic [WIN_W-1:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  window_meter_board board = new();
  logic [TS_W-1:0]   stamp_now[2];
  bit                no_idle      = 1'b0;
  bit                hold_off_req = 1'b0;

  sliding_window_packet_meter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // offer one packet event and wait for its transfer
  task automatic send_packet(logic ch, logic [TS_W-1:0] ts, logic [NB_W-1:0] nb);
    int gap_cycles;
    gap_cycles = draw_idle();
    if (gap_cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nb, ts};
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_packet(ch, ts, nb);
    if (stamp_now[ch] == '0 || ts >= stamp_now[ch]) stamp_now[ch] = ts;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // window change only with the block idle
  task automatic write_window(logic idx, logic [WIN_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_window(idx, value);
  endtask

  // mostly rising stamps per channel, some repeats and jumps, some going backwards
  task automatic run_phase(int n, int send_pct, int gap_max, int noise_pct);
    logic              ch;
    logic [63:0]       r;
    logic [TS_W-1:0]   ts;
    logic [NB_W-1:0]   nb;
    int                pick;
    for (int i = 0; i < n; i++) begin
      ch   = ($urandom_range(0, 99) < send_pct) ? CH_SEND : CH_RECV;
      pick = $urandom_range(0, 99);
      r    = {$urandom, $urandom};
      if (stamp_now[ch] != '0 && pick < noise_pct) begin
        ts = (pick == 0) ? '0 : 48'(r % {16'd0, stamp_now[ch]});
      end else if (pick < noise_pct + 10) begin
        ts = stamp_now[ch];
      end else if (pick < noise_pct + 12) begin
        ts = stamp_now[ch] + {16'd0, r[31:0]};
      end else if (pick < noise_pct + 13 && $urandom_range(0, 9) == 0) begin
        ts = stamp_now[ch] + {8'd0, r[39:0]};
      end else begin
        ts = stamp_now[ch] + TS_W'($urandom_range(0, gap_max));
      end
      case ($urandom_range(0, 9))
        0:       nb = '0;
        1:       nb = BYTES_MAX;
        default: nb = NB_W'($urandom);
      endcase
      send_packet(ch, ts, nb);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        stall = 0;
      end else begin
        stall = draw_idle();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_sums(m_axis_tdata, m_axis_tuser);
    end
  end

  // stimulus and end of run
  initial begin
    stamp_now[0] = '0;
    stamp_now[1] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first packets, stored stamp zero, multi-entry eviction, backwards stamps
    send_packet(CH_SEND, 48'd0, 16'd0);
    send_packet(CH_SEND, 48'd0, BYTES_MAX);
    send_packet(CH_SEND, 48'd100, 16'd1);
    send_packet(CH_SEND, 48'd600000, 16'h8000);
    send_packet(CH_SEND, 48'd1700000, 16'h00ff);
    send_packet(CH_SEND, 48'd50, 16'd9);
    send_packet(CH_SEND, 48'd0, 16'd9);
    send_packet(CH_RECV, 48'd5, 16'd7);
    send_packet(CH_RECV, 48'd5, 16'd3);
    send_packet(CH_RECV, 48'd4, 16'd3);
    // zero window empties the fifo, new entry included
    write_window(REG_SEND_WINDOW, '0);
    write_window(REG_RECV_WINDOW, '0);
    send_packet(CH_SEND, 48'd1700001, 16'h1234);
    send_packet(CH_RECV, 48'd10, 16'hfedc);
    write_window(REG_SEND_WINDOW, WINDOW_MAX);
    write_window(REG_RECV_WINDOW, WINDOW_MAX);
    send_packet(CH_SEND, 48'd2700001, 16'h00aa);
    send_packet(CH_RECV, 48'd1000010, 16'h5500);
    write_window(REG_SEND_WINDOW, WINDOW_RESET);
    write_window(REG_RECV_WINDOW, WINDOW_RESET);

    // default windows, both channels
    run_phase(300, 50, 20000, 8);

    // send side fills its fifo while results are held back
    write_window(REG_SEND_WINDOW, WINDOW_MAX);
    write_window(REG_RECV_WINDOW, WIN_W'($urandom_range(1, 5000)));
    hold_off_req = 1'b1;
    run_phase(380, 90, 2000, 3);

    // receive side fills its fifo
    write_window(REG_SEND_WINDOW, WIN_W'($urandom_range(1000, 3000000)));
    write_window(REG_RECV_WINDOW, WINDOW_MAX);
    run_phase(380, 10, 2000, 3);

    // zero windows, back to back transfers
    write_window(REG_SEND_WINDOW, '0);
    write_window(REG_RECV_WINDOW, '0);
    no_idle = 1'b1;
    run_phase(150, 50, 5000, 8);
    no_idle = 1'b0;

    // tiny windows
    write_window(REG_SEND_WINDOW, WIN_W'($urandom_range(1, 100)));
    write_window(REG_RECV_WINDOW, WIN_W'($urandom_range(1, 100)));
    run_phase(300, 50, 60, 8);

    // default windows again, wider gaps
    write_window(REG_SEND_WINDOW, WINDOW_RESET);
    write_window(REG_RECV_WINDOW, WINDOW_RESET);
    run_phase(320, 50, 40000, 10);

    // top of the stamp range
    send_packet(CH_SEND, STAMP_MAX, BYTES_MAX);
    send_packet(CH_SEND, STAMP_MAX, 16'd1);
    send_packet(CH_SEND, '0, BYTES_MAX);
    send_packet(CH_RECV, STAMP_MAX, BYTES_MAX);

    drain();
    repeat (20) @(posedge clk_i);
    $display("checked %0d results: %0d backwards stamps, %0d evictions, %0d full fifo drops",
             board.checked, board.rejects, board.evictions, board.full_drops);
    $display("%0d results left a channel empty; windows ran from zero to full scale",
             board.empty_windows);
    if (board.errors == 0 && board.pending_sums.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/swpm_pkg.sv
hw/rtl/swpm_store.sv
hw/rtl/swpm_engine.sv
hw/rtl/sliding_window_packet_meter_core.sv
hw/rtl/swpm_checker.sv
verif/sliding_window_packet_meter_core_tb.sv
